/* src/ssd_pkg.sv */
// Package for specular_scatter_direction: stage numbering, pipeline item type and
// saturation helpers. No dependencies.
package ssd_pkg;

  localparam int NS       = 69;
  localparam int ST_SUM   = 1;
  localparam int ST_RND   = 2;
  localparam int ST_SQ    = 3;
  localparam int ST_S2    = 4;
  localparam int ST_LHS   = 5;
  localparam int ST_TIR   = 6;
  localparam int ST_KDIV  = 7;
  localparam int KDIV_N   = 29;
  localparam int ST_EDIV  = 3;
  localparam int EDIV_N   = 33;
  localparam int ST_SDIV  = 3;
  localparam int SDIV_N   = 16;
  localparam int ST_ROOT  = 36;
  localparam int ROOT_N   = 29;
  localparam int ST_ETAC  = 65;
  localparam int ST_M16   = 66;
  localparam int ST_MUL   = 67;
  localparam int ST_OUT   = 68;

  typedef struct packed {
    logic                  kind;
    logic                  leaving;
    logic [7:0]            depth;
    logic [7:0]            level;
    logic [15:0]           scale;
    logic [15:0]           n1;
    logic [15:0]           n2;
    logic [47:0]           dv;
    logic [47:0]           nv;
    logic [62:0]           pv;
    logic [2:0][31:0]      prod;
    logic [2:0][26:0]      goff;
    logic [2:0][13:0]      off;
    logic [31:0]           n1sq;
    logic [31:0]           n2sq;
    logic [31:0]           sn2;
    logic [47:0]           sn2n2;
    logic [32:0]           ne;
    logic signed [33:0]    dd;
    logic signed [19:0]    c;
    logic [39:0]           c2;
    logic [28:0]           s2;
    logic [2:0][49:0]      rp;
    logic [2:0][15:0]      refl;
    logic [2:0][20:0]      o_pos;
    logic [2:0][20:0]      o_neg;
    logic [60:0]           lhs;
    logic                  tir;
    logic [60:0]           diff;
    logic [31:0]           krem;
    logic [28:0]           kq;
    logic [15:0]           erem;
    logic [32:0]           eq;
    logic [48:0]           num_s;
    logic                  qsat;
    logic [31:0]           srem;
    logic [15:0]           sq;
    logic [56:0]           sx;
    logic [57:0]           sr;
    logic signed [53:0]    eta_c;
    logic signed [40:0]    m16;
    logic [2:0][49:0]      ed;
    logic [2:0][56:0]      mn;
    logic [47:0]           o_dir;
    logic [62:0]           o_org;
    logic [15:0]           o_ior;
    logic [7:0]            o_depth;
    logic [7:0]            o_level;
    logic [15:0]           o_scale;
    logic                  o_refr;
    logic                  o_tir;
  } item_t;

  function automatic logic [15:0] sat16(input logic signed [63:0] v);
    if (v < -64'sd32768) return 16'h8000;
    if (v > 64'sd32767) return 16'h7fff;
    return v[15:0];
  endfunction

  function automatic logic [20:0] sat21(input logic signed [63:0] v);
    if (v < -64'sd1048576) return 21'h100000;
    if (v > 64'sd1048575) return 21'h0fffff;
    return v[20:0];
  endfunction

endpackage

/* src/specular_scatter_direction.sv */
// specular_scatter_direction: reflect / refract a ray at a specular hit, fixed point.
// Depends on ssd_pkg (item type, stage numbering, saturation helpers).
//
//   channel | handshake         | payload
//   in      | in_valid/in_stall | kind, dirs, normals, position, IORs, counters
//   out     | out_valid/out_stall | direction, origin, IOR, counters, flags
//   cfg     | cfg_valid/cfg_ready | cfg_data = offset epsilon (10 bit)
//
// 69-stage pipeline, one transfer per cycle while the output is not stalled.
// The depth is set by the bit-serial stages: 29 for k = (n2^2 - n1^2 sin^2)/n2^2,
// then 29 for the square root, with eta and scale dividers running beside them.
// Each stage has its own valid bit and fills bubbles while the output is stalled.
// Synchronous active-low reset clears the valid bits and sets epsilon to 1.
module specular_scatter_direction (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_kind,
  input  logic [47:0] in_incoming_dir,
  input  logic [47:0] in_specular_normal,
  input  logic [47:0] in_surface_normal,
  input  logic [62:0] in_hit_position,
  input  logic [15:0] in_ior_near,
  input  logic [15:0] in_ior_far,
  input  logic        in_inside_req,
  input  logic [7:0]  in_bounce_depth,
  input  logic signed [7:0] in_nest_level,
  input  logic [15:0] in_radiance_scale,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [47:0] out_dir,
  output logic [62:0] out_origin,
  output logic [15:0] out_ior,
  output logic [7:0]  out_depth,
  output logic signed [7:0] out_level,
  output logic [15:0] out_scale,
  output logic        out_refracted,
  output logic        out_total_internal,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [9:0]  cfg_data
);
  import ssd_pkg::*;

  logic [9:0] eps_r;
  item_t      st_r  [NS];
  logic       vld_r [NS];
  wire [NS:0] en;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eps_r <= 10'd1;
    end else if (cfg_valid && cfg_ready) begin
      eps_r <= cfg_data;
    end
  end

  assign en[NS]   = !out_stall;
  assign in_stall = !en[0];

  for (genvar s = 0; s < NS; s++) begin : g_st
    item_t nxt;

    assign en[s] = !vld_r[s] || en[s+1];

    if (s == 0) begin : g_in
      always_comb begin
        logic [15:0] n1;
        logic [15:0] n2;
        nxt         = '0;
        n1          = (in_ior_near == 16'd0) ? 16'd1 : in_ior_near;
        n2          = (in_ior_far == 16'd0) ? 16'd1 : in_ior_far;
        nxt.kind    = in_kind;
        nxt.leaving = in_inside_req;
        nxt.depth   = in_bounce_depth;
        nxt.level   = in_nest_level;
        nxt.scale   = in_radiance_scale;
        nxt.n1      = n1;
        nxt.n2      = n2;
        nxt.dv      = in_incoming_dir;
        nxt.nv      = in_specular_normal;
        nxt.pv      = in_hit_position;
        for (int i = 0; i < 3; i++) begin
          nxt.prod[i] = $signed(in_incoming_dir[16*(2-i) +: 16]) *
                        $signed(in_specular_normal[16*(2-i) +: 16]);
          nxt.goff[i] = $signed(in_surface_normal[16*(2-i) +: 16]) *
                        $signed({1'b0, eps_r});
        end
        nxt.n1sq = n1 * n1;
        nxt.n2sq = n2 * n2;
        nxt.sn2  = in_radiance_scale * n2;
        nxt.ne   = {1'b0, n1, 16'b0} + 33'(n2 >> 1);
      end
    end else begin : g_wk
      localparam int KB = (s >= ST_KDIV && s < ST_KDIV + KDIV_N) ? ST_KDIV + KDIV_N - 1 - s : 0;
      localparam int EB = (s >= ST_EDIV && s < ST_EDIV + EDIV_N) ? ST_EDIV + EDIV_N - 1 - s : 0;
      localparam int SB = (s >= ST_SDIV && s < ST_SDIV + SDIV_N) ? ST_SDIV + SDIV_N - 1 - s : 0;
      localparam int SJ = (s >= ST_ROOT && s < ST_ROOT + ROOT_N) ? ST_ROOT + ROOT_N - 1 - s : 0;

      always_comb begin
        item_t              pv;
        logic signed [33:0] t_dd;
        logic signed [26:0] t_go;
        logic signed [21:0] t_o;
        logic signed [51:0] t_v;
        logic signed [57:0] t_w;
        logic signed [54:0] t_m;
        logic [48:0]        t_ns;
        logic [60:0]        t_rhs;
        logic [32:0]        t_k;
        logic [16:0]        t_e;
        logic [32:0]        t_s;
        logic [56:0]        t_x;
        logic [57:0]        t_r;
        logic [57:0]        t_rb;
        logic               trans;
        pv    = st_r[s-1];
        nxt   = pv;
        t_dd  = '0;
        t_go  = '0;
        t_o   = '0;
        t_v   = '0;
        t_w   = '0;
        t_m   = '0;
        t_ns  = '0;
        t_rhs = '0;
        t_k   = '0;
        t_e   = '0;
        t_s   = '0;
        t_x   = '0;
        t_r   = '0;
        t_rb  = '0;
        trans = 1'b0;

        if (s == ST_SUM) begin
          t_dd      = $signed(pv.prod[0]) + $signed(pv.prod[1]) + $signed(pv.prod[2]);
          nxt.dd    = t_dd;
          nxt.sn2n2 = pv.sn2 * pv.n2;
          for (int i = 0; i < 3; i++) begin
            t_go       = $signed(pv.goff[i]) + 27'sd8192;
            nxt.off[i] = 14'(t_go >>> 14);
          end
        end

        if (s == ST_RND) begin
          t_dd  = pv.dd + 34'sd8192;
          nxt.c = 20'(t_dd >>> 14);
          for (int i = 0; i < 3; i++) begin
            nxt.rp[i]    = 50'(pv.dd * $signed(pv.nv[16*(2-i) +: 16]));
            t_o          = $signed(pv.pv[21*(2-i) +: 21]) + $signed(pv.off[i]);
            nxt.o_pos[i] = sat21(t_o);
            t_o          = $signed(pv.pv[21*(2-i) +: 21]) - $signed(pv.off[i]);
            nxt.o_neg[i] = sat21(t_o);
          end
          t_ns      = {1'b0, pv.sn2n2} + 49'(pv.n1sq >> 1);
          nxt.num_s = t_ns;
          nxt.qsat  = t_ns >= {1'b0, pv.n1sq, 16'b0};
          nxt.srem  = t_ns[47:16];
        end

        if (s == ST_SQ) begin
          nxt.c2 = 40'(pv.c * pv.c);
          for (int i = 0; i < 3; i++) begin
            t_v = ($signed(pv.dv[16*(2-i) +: 16]) <<< 28) - ($signed(pv.rp[i]) <<< 1)
                  + 52'sd134217728;
            nxt.refl[i] = sat16(t_v >>> 28);
          end
        end

        if (s == ST_S2) begin
          nxt.s2 = (pv.c2 < 40'd268435456) ? 29'(40'd268435456 - pv.c2) : 29'd0;
        end

        if (s == ST_LHS) begin
          nxt.lhs = pv.n1sq * pv.s2;
        end

        if (s == ST_TIR) begin
          t_rhs    = {1'b0, pv.n2sq, 28'b0};
          nxt.tir  = pv.kind && (pv.lhs > t_rhs);
          nxt.diff = t_rhs - pv.lhs;
          nxt.krem = {1'b0, nxt.diff[59:29]};
          nxt.kq   = '0;
        end

        if (s >= ST_KDIV && s < ST_KDIV + KDIV_N) begin
          t_k = {pv.krem, pv.diff[KB]};
          if (t_k >= {1'b0, pv.n2sq}) begin
            nxt.krem = 32'(t_k - {1'b0, pv.n2sq});
            nxt.kq   = {pv.kq[27:0], 1'b1};
          end else begin
            nxt.krem = t_k[31:0];
            nxt.kq   = {pv.kq[27:0], 1'b0};
          end
        end

        if (s >= ST_EDIV && s < ST_EDIV + EDIV_N) begin
          t_e = {pv.erem, pv.ne[EB]};
          if (t_e >= {1'b0, pv.n2}) begin
            nxt.erem = 16'(t_e - {1'b0, pv.n2});
            nxt.eq   = {pv.eq[31:0], 1'b1};
          end else begin
            nxt.erem = t_e[15:0];
            nxt.eq   = {pv.eq[31:0], 1'b0};
          end
        end

        if (s >= ST_SDIV && s < ST_SDIV + SDIV_N) begin
          t_s = {pv.srem, pv.num_s[SB]};
          if (t_s >= {1'b0, pv.n1sq}) begin
            nxt.srem = 32'(t_s - {1'b0, pv.n1sq});
            nxt.sq   = {pv.sq[14:0], 1'b1};
          end else begin
            nxt.srem = t_s[31:0];
            nxt.sq   = {pv.sq[14:0], 1'b0};
          end
        end

        if (s >= ST_ROOT && s < ST_ROOT + ROOT_N) begin
          t_x  = (s == ST_ROOT) ? {pv.kq, 28'b0} : pv.sx;
          t_r  = (s == ST_ROOT) ? 58'd0 : pv.sr;
          t_rb = t_r + (58'd1 << (2 * SJ));
          if ({1'b0, t_x} >= t_rb) begin
            nxt.sx = 57'({1'b0, t_x} - t_rb);
            nxt.sr = (t_r >> 1) + (58'd1 << (2 * SJ));
          end else begin
            nxt.sx = t_x;
            nxt.sr = t_r >> 1;
          end
        end

        if (s == ST_ETAC) begin
          nxt.eta_c = $signed({1'b0, pv.eq}) * pv.c;
        end

        if (s == ST_M16) begin
          t_m     = pv.eta_c + $signed({24'b0, pv.sr[28:0], 2'b0}) + 55'sd8192;
          nxt.m16 = 41'(t_m >>> 14);
        end

        if (s == ST_MUL) begin
          for (int i = 0; i < 3; i++) begin
            nxt.ed[i] = 50'($signed({1'b0, pv.eq}) * $signed(pv.dv[16*(2-i) +: 16]));
            nxt.mn[i] = 57'(pv.m16 * $signed(pv.nv[16*(2-i) +: 16]));
          end
        end

        if (s == ST_OUT) begin
          trans = pv.kind && !pv.tir;
          for (int i = 0; i < 3; i++) begin
            t_w = $signed(pv.ed[i]) - $signed(pv.mn[i]) + 58'sd32768;
            nxt.o_dir[16*(2-i) +: 16] = trans ? sat16(t_w >>> 16) : pv.refl[i];
            nxt.o_org[21*(2-i) +: 21] = trans ? pv.o_neg[i] : pv.o_pos[i];
          end
          nxt.o_ior   = trans ? pv.n2 : pv.n1;
          nxt.o_depth = (pv.depth == 8'hff) ? 8'hff : pv.depth + 8'd1;
          if (!trans) begin
            nxt.o_level = pv.level;
            nxt.o_scale = pv.scale;
          end else begin
            if (pv.leaving) begin
              nxt.o_level = (pv.level == 8'h80) ? 8'h80 : pv.level - 8'd1;
            end else begin
              nxt.o_level = (pv.level == 8'h7f) ? 8'h7f : pv.level + 8'd1;
            end
            nxt.o_scale = pv.qsat ? 16'hffff : pv.sq;
          end
          nxt.o_refr = trans;
          nxt.o_tir  = pv.tir;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en[s]) begin
        st_r[s] <= nxt;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else if (en[s]) begin
        vld_r[s] <= (s == 0) ? in_valid : vld_r[(s == 0) ? 0 : s-1];
      end
    end
  end

  assign out_valid          = vld_r[NS-1];
  assign out_dir            = st_r[NS-1].o_dir;
  assign out_origin         = st_r[NS-1].o_org;
  assign out_ior            = st_r[NS-1].o_ior;
  assign out_depth          = st_r[NS-1].o_depth;
  assign out_level          = st_r[NS-1].o_level;
  assign out_scale          = st_r[NS-1].o_scale;
  assign out_refracted      = st_r[NS-1].o_refr;
  assign out_total_internal = st_r[NS-1].o_tir;

endmodule

/* sim/specular_scatter_direction_checker.sv */
// Checker for specular_scatter_direction: watches the in, out and cfg channels,
// predicts each result in fixed point and compares it field by field.
// Depends on nothing but the block's port widths.
module specular_scatter_direction_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        in_kind,
  input  logic [47:0] in_incoming_dir,
  input  logic [47:0] in_specular_normal,
  input  logic [47:0] in_surface_normal,
  input  logic [62:0] in_hit_position,
  input  logic [15:0] in_ior_near,
  input  logic [15:0] in_ior_far,
  input  logic        in_inside_req,
  input  logic [7:0]  in_bounce_depth,
  input  logic [7:0]  in_nest_level,
  input  logic [15:0] in_radiance_scale,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [47:0] out_dir,
  input  logic [62:0] out_origin,
  input  logic [15:0] out_ior,
  input  logic [7:0]  out_depth,
  input  logic [7:0]  out_level,
  input  logic [15:0] out_scale,
  input  logic        out_refracted,
  input  logic        out_total_internal,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [9:0]  cfg_data,
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QDEPTH = 4096;

  typedef struct packed {
    logic [47:0] dir;
    logic [62:0] origin;
    logic [15:0] ior;
    logic [7:0]  depth;
    logic [7:0]  level;
    logic [15:0] scale;
    logic        refr;
    logic        tir;
  } scatter_t;

  scatter_t   expected_rays [QDEPTH];
  int         wr_cnt, rd_cnt;
  logic [9:0] epsilon;

  // round(v / 2^s), halves up (arithmetic shift floors)
  function automatic longint round_shift(longint v, int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clampv(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint sx(logic [63:0] v, int bits);
    logic [63:0] m;
    m = (64'd1 << bits) - 1;
    v &= m;
    if (v[bits-1]) return longint'(v | ~m);
    return longint'(v);
  endfunction

  function automatic longint int_sqrt(logic [63:0] x);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return longint'(r);
  endfunction

  function automatic scatter_t scatter_ray(
    logic kind, logic [47:0] dv, logic [47:0] nv, logic [47:0] gv, logic [62:0] pv,
    logic [15:0] ior1, logic [15:0] ior2, logic leaving, logic [7:0] depth,
    logic [7:0] lvl, logic [15:0] scl, logic [9:0] eps);
    scatter_t res;
    longint d[3], n[3], g[3], p[3], r[3], o[3];
    longint dd, c, c2, eta, m16, root, off, level;
    logic [63:0] n1, n2, s2, lhs, rhs, k28, num, den, q;
    logic transmit, tir;
    int sgn;
    n1 = ior1 == 0 ? 64'd1 : 64'(ior1);
    n2 = ior2 == 0 ? 64'd1 : 64'(ior2);
    transmit = 0;
    tir = 0;
    level = sx(lvl, 8);
    for (int i = 0; i < 3; i++) begin
      d[i] = sx(dv >> (32 - 16*i), 16);
      n[i] = sx(nv >> (32 - 16*i), 16);
      g[i] = sx(gv >> (32 - 16*i), 16);
      p[i] = sx(pv >> (42 - 21*i), 21);
    end
    dd = d[0]*n[0] + d[1]*n[1] + d[2]*n[2];
    c = round_shift(dd, 14);
    if (kind) begin
      c2 = c * c;
      s2 = c2 < (64'sd1 <<< 28) ? 64'((64'sd1 <<< 28) - c2) : 64'd0;
      lhs = n1 * n1 * s2;
      rhs = (n2 * n2) << 28;
      if (lhs > rhs) begin
        tir = 1;
      end else begin
        k28 = (rhs - lhs) / (n2 * n2);
        root = int_sqrt(k28 << 28);
        eta = longint'(((n1 << 16) + n2 / 2) / n2);
        m16 = round_shift(eta * c + root * 4, 14);
        for (int i = 0; i < 3; i++)
          r[i] = clampv(round_shift(eta * d[i] - m16 * n[i], 16), -32768, 32767);
        transmit = 1;
      end
    end
    if (!transmit)
      for (int i = 0; i < 3; i++)
        r[i] = clampv(round_shift(d[i] * (64'sd1 <<< 28) - 2 * dd * n[i], 28),
                      -32768, 32767);
    sgn = transmit ? -1 : 1;
    for (int i = 0; i < 3; i++) begin
      off = round_shift(g[i] * longint'(eps), 14);
      o[i] = clampv(p[i] + sgn * off, -(64'sd1 <<< 20), (64'sd1 <<< 20) - 1);
    end
    res.scale = scl;
    if (transmit) begin
      num = 64'(scl) * n2 * n2;
      den = n1 * n1;
      q = (num + den / 2) / den;
      res.scale = q > 64'hffff ? 16'hffff : q[15:0];
      level = clampv(leaving ? level - 1 : level + 1, -128, 127);
    end
    res.dir = {r[0][15:0], r[1][15:0], r[2][15:0]};
    res.origin = {o[0][20:0], o[1][20:0], o[2][20:0]};
    res.ior = transmit ? n2[15:0] : n1[15:0];
    res.depth = depth == 8'hff ? 8'hff : depth + 8'd1;
    res.level = level[7:0];
    res.refr = transmit;
    res.tir = tir;
    return res;
  endfunction

  assign pending = wr_cnt - rd_cnt;

  always @(posedge clk) begin
    scatter_t got, want;
    if (!rst_n) begin
      epsilon <= 10'd1;
      wr_cnt <= 0;
      rd_cnt <= 0;
      fail_count <= 0;
    end else begin
      if (cfg_valid && cfg_ready) epsilon <= cfg_data;
      if (in_valid && !in_stall) begin
        expected_rays[wr_cnt % QDEPTH] <= scatter_ray(in_kind, in_incoming_dir,
          in_specular_normal, in_surface_normal, in_hit_position, in_ior_near,
          in_ior_far, in_inside_req, in_bounce_depth, in_nest_level,
          in_radiance_scale, epsilon);
        wr_cnt <= wr_cnt + 1;
      end
      if (out_valid && !out_stall) begin
        got = {out_dir, out_origin, out_ior, out_depth, out_level, out_scale,
               out_refracted, out_total_internal};
        if (rd_cnt == wr_cnt) begin
          $display("%0t: unexpected transfer, actual %h", $time, got);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_rays[rd_cnt % QDEPTH];
          rd_cnt <= rd_cnt + 1;
          if (got !== want) begin
            $display("%0t: mismatch dir exp %h act %h, origin exp %h act %h", $time,
                     want.dir, got.dir, want.origin, got.origin);
            $display({"%0t:   ior/depth/level/scale/refr/tir exp %h %h %h %h %b %b",
                      " act %h %h %h %h %b %b"},
                     $time, want.ior, want.depth, want.level, want.scale, want.refr,
                     want.tir, got.ior, got.depth, got.level, got.scale, got.refr,
                     got.tir);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

/* sim/specular_scatter_direction_test.sv */
// Testbench top for specular_scatter_direction: drives directed and random hits
// with random idling, sets epsilon between phases and gives the verdict.
// Depends on specular_scatter_direction and specular_scatter_direction_checker.
module specular_scatter_direction_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [15:0] ONE_Q14 = 16'h4000;
  localparam logic [15:0] ONE_IOR = 16'h1000;
  localparam int DRAIN_CYCLES = 200;
  localparam int CYCLE_LIMIT = 400000;

  logic clk, rst_n;
  logic in_valid, in_stall, in_kind, in_inside_req;
  logic [47:0] in_incoming_dir, in_specular_normal, in_surface_normal;
  logic [62:0] in_hit_position;
  logic [15:0] in_ior_near, in_ior_far, in_radiance_scale;
  logic [7:0] in_bounce_depth;
  logic signed [7:0] in_nest_level;
  logic out_valid, out_stall, out_refracted, out_total_internal;
  logic [47:0] out_dir;
  logic [62:0] out_origin;
  logic [15:0] out_ior, out_scale;
  logic [7:0] out_depth;
  logic signed [7:0] out_level;
  logic cfg_valid, cfg_ready;
  logic [9:0] cfg_data;
  int fail_count, pending;
  int cycles = 0;
  bit calm, drive_done;

  specular_scatter_direction u_dut (.*);
  specular_scatter_direction_checker u_chk (.*);

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[specular_scatter_direction] ERROR");
      $finish;
    end
  end

  // receiver stalls in bursts
  initial begin
    int n;
    out_stall = 0;
    forever begin
      @(posedge clk);
      if (!calm && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 10);
        out_stall <= 1;
        repeat (n) @(posedge clk);
        out_stall <= 0;
      end
    end
  end

  function automatic logic [47:0] rand_vec(bit unit);
    logic [15:0] c[3];
    for (int i = 0; i < 3; i++)
      c[i] = unit ? 16'($signed($urandom_range(0, 32768)) - 16384) : 16'($urandom);
    if (unit && $urandom_range(0, 1)) begin
      c[0] = $urandom_range(0, 1) ? ONE_Q14 : -ONE_Q14;
      c[1] = 0;
      c[2] = 16'($urandom_range(0, 3000));
    end
    return {c[0], c[1], c[2]};
  endfunction

  task automatic send_hit(logic kind, logic [47:0] d, logic [47:0] n, logic [47:0] g,
                          logic [62:0] p, logic [15:0] i1, logic [15:0] i2);
    int gap;
    if (!calm && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 10);
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    in_kind <= kind;
    in_incoming_dir <= d;
    in_specular_normal <= n;
    in_surface_normal <= g;
    in_hit_position <= p;
    in_ior_near <= i1;
    in_ior_far <= i2;
    in_inside_req <= 1'($urandom_range(0, 1));
    in_bounce_depth <= $urandom_range(0, 3) == 0 ? 8'(8'hff - $urandom_range(0, 1))
                                                 : 8'($urandom);
    in_nest_level <= $urandom_range(0, 3) == 0 ? ($urandom_range(0, 1) ? 8'sh7f : -8'sd128)
                                               : 8'($urandom);
    in_radiance_scale <= $urandom_range(0, 4) == 0 ? 16'hffff : 16'($urandom);
    do @(posedge clk); while (in_stall);
  endtask

  task automatic random_hit();
    logic [15:0] i1, i2;
    bit wild;
    wild = $urandom_range(0, 9) == 0;
    case ($urandom_range(0, 3))
      0: i1 = ONE_IOR;
      1: i1 = 16'($urandom_range(4000, 8000));
      2: i1 = 16'($urandom_range(0, 1));
      default: i1 = 16'($urandom);
    endcase
    i2 = $urandom_range(0, 2) == 0 ? ONE_IOR : ($urandom_range(0, 5) == 0 ? 16'($urandom)
                                                : 16'($urandom_range(4000, 8000)));
    send_hit($urandom_range(0, 3) != 0, rand_vec(!wild), rand_vec(!wild),
             rand_vec($urandom_range(0, 3) != 0), 63'({$urandom, $urandom}), i1, i2);
  endtask

  task automatic write_epsilon(logic [9:0] v);
    in_valid <= 0;
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_valid <= 1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
  endtask

  initial begin
    logic [9:0] eps_set[4];
    eps_set = '{10'd0, 10'd1023, 10'd37, 10'd512};
    rst_n = 0; in_valid = 0; in_kind = 0; in_inside_req = 0;
    in_incoming_dir = 0; in_specular_normal = 0; in_surface_normal = 0;
    in_hit_position = 0; in_ior_near = ONE_IOR; in_ior_far = ONE_IOR;
    in_bounce_depth = 0; in_nest_level = 0; in_radiance_scale = 0;
    cfg_valid = 0; cfg_data = 0; calm = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // directed: mirror, straight refract, TIR, zero IORs, grazing, field extremes
    send_hit(0, {ONE_Q14, 32'h0}, {16'h0, ONE_Q14, 16'h0}, {3{ONE_Q14}}, 63'h0,
             ONE_IOR, ONE_IOR);
    send_hit(1, {32'h0, -ONE_Q14}, {32'h0, ONE_Q14}, {32'h0, ONE_Q14}, {63{1'b1}},
             ONE_IOR, 16'h1800);
    send_hit(1, {ONE_Q14, 32'h0}, {32'h0, ONE_Q14}, {32'h0, ONE_Q14}, 63'h0,
             16'h2000, ONE_IOR);
    send_hit(1, {ONE_Q14, 32'h0}, {32'h0, ONE_Q14}, {3{16'h8000}}, {1'b0, {62{1'b1}}},
             16'h0, 16'h0);
    send_hit(1, {ONE_Q14, 32'h0}, {32'h0, ONE_Q14}, {3{16'h7fff}}, 63'h0, ONE_IOR, ONE_IOR);
    send_hit(1, {3{16'h7fff}}, {3{16'h8000}}, {3{16'h7fff}}, {3{21'h0fffff}},
             16'hffff, 16'h1);
    send_hit(1, {3{16'h8000}}, {3{16'h8000}}, {3{16'h8000}}, {3{21'h100000}},
             16'h1, 16'hffff);
    send_hit(0, {3{16'h7fff}}, {3{16'h7fff}}, 48'h0, {63{1'b1}}, 16'hffff, 16'hffff);
    send_hit(1, {16'h2d41, 16'h0, 16'hd2bf}, {32'h0, ONE_Q14}, {32'h0, ONE_Q14}, 63'h0,
             16'h1800, ONE_IOR);
    for (int i = 0; i < 12; i++) random_hit();
    for (int ph = 0; ph < 4; ph++) begin
      write_epsilon(eps_set[ph]);
      for (int i = 0; i < 270; i++) begin
        if (ph == 3 && i > 200) calm = 1;
        random_hit();
      end
    end
    in_valid <= 0;
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("[specular_scatter_direction] OK");
    else
      $display("[specular_scatter_direction] ERROR");
    $finish;
  end
endmodule
